FILE: design/tlhic_pkg.sv
// ----------------------------------------------------------------------------
// tlhic_pkg: shared types and constants for the tank level heater interlock
// Register map, run state codes, config and result structs, drive saturation.
// ----------------------------------------------------------------------------
package tlhic_pkg;

  // drive range: 0..100% in sixteenths of a percent
  localparam int unsigned DRIVE_W   = 11;
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 11'd1600;

  // level gain 0.8 as 205/256
  localparam int unsigned GAIN_NUM   = 205;
  localparam int unsigned GAIN_SHIFT = 8;

  // APB register map, one 64-bit register every 8 bytes
  localparam int unsigned PADDR_W = 6;
  localparam int unsigned PDATA_W = 64;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_RUN_MODE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_LVL  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_TMP  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOW_ALARM   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_ALARM  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN_HEATER  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX_FILL    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MANUAL      = 3'd7;

  // run modes
  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_MANUAL  = 2'd1;

  // run state codes
  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_STARTING = 2'd1;
  localparam logic [1:0] ST_RUNNING  = 2'd2;
  localparam logic [1:0] ST_FAULTED  = 2'd3;

  typedef struct packed {
    logic [1:0]  run_mode;
    logic [15:0] target_level;
    logic [15:0] target_temperature;
    logic [15:0] low_alarm_level;
    logic [15:0] high_alarm_level;
    logic [15:0] min_heater_level;
    logic [15:0] max_fill_level;
    logic [32:0] manual_drives;
  } cfg_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] pump_drive;
    logic [DRIVE_W-1:0] valve_drive;
    logic [DRIVE_W-1:0] heater_drive;
    logic               sample_fault;
    logic               safe_state;
    logic               low_level_alarm;
    logic               high_level_alarm;
    logic               heater_lockout;
  } result_t;

  // saturate an unsigned value to the drive range
  function automatic logic [DRIVE_W-1:0] sat_drive(input logic [15:0] v);
    if (v > 16'(DRIVE_MAX)) begin
      return DRIVE_MAX;
    end
    return v[DRIVE_W-1:0];
  endfunction

endpackage

FILE: design/tlhic_regs.sv
// ----------------------------------------------------------------------------
// tlhic_regs: configuration register file
// APB write and read of the eight control registers; flags mode writes.
// ----------------------------------------------------------------------------
module tlhic_regs import tlhic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg,
  output logic               mode_wr
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready  = 1'b1;
  assign idx     = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign mode_wr = wr_en && (idx == REG_RUN_MODE);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_mode           <= MODE_STOPPED;
      cfg.target_level       <= '0;
      cfg.target_temperature <= '0;
      cfg.low_alarm_level    <= '0;
      cfg.high_alarm_level   <= 16'hFFFF;
      cfg.min_heater_level   <= '0;
      cfg.max_fill_level     <= 16'hFFFF;
      cfg.manual_drives      <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_RUN_MODE:   cfg.run_mode           <= pwdata[1:0];
        REG_TARGET_LVL: cfg.target_level       <= pwdata[15:0];
        REG_TARGET_TMP: cfg.target_temperature <= pwdata[15:0];
        REG_LOW_ALARM:  cfg.low_alarm_level    <= pwdata[15:0];
        REG_HIGH_ALARM: cfg.high_alarm_level   <= pwdata[15:0];
        REG_MIN_HEATER: cfg.min_heater_level   <= pwdata[15:0];
        REG_MAX_FILL:   cfg.max_fill_level     <= pwdata[15:0];
        REG_MANUAL:     cfg.manual_drives      <= pwdata[32:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_RUN_MODE:   prdata = PDATA_W'(cfg.run_mode);
      REG_TARGET_LVL: prdata = PDATA_W'(cfg.target_level);
      REG_TARGET_TMP: prdata = PDATA_W'(cfg.target_temperature);
      REG_LOW_ALARM:  prdata = PDATA_W'(cfg.low_alarm_level);
      REG_HIGH_ALARM: prdata = PDATA_W'(cfg.high_alarm_level);
      REG_MIN_HEATER: prdata = PDATA_W'(cfg.min_heater_level);
      REG_MAX_FILL:   prdata = PDATA_W'(cfg.max_fill_level);
      REG_MANUAL:     prdata = PDATA_W'(cfg.manual_drives);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: design/tlhic_core.sv
// ----------------------------------------------------------------------------
// tlhic_core: per-sample control law and interlocks
// Manual pass-through or proportional drive, clamps, alarms, safety cuts.
// ----------------------------------------------------------------------------
module tlhic_core import tlhic_pkg::*; (
  input  cfg_t        cfg,
  input  logic [15:0] level_value,
  input  logic        level_good,
  input  logic [15:0] temperature_value,
  input  logic        temperature_good,
  output result_t     res,
  output logic [1:0]  state_next
);

  logic               fault;
  logic               low;
  logic               high;
  logic               below_min;
  logic [16:0]        lvl_err;
  logic [15:0]        err_mag;
  logic [23:0]        err_prod;
  logic [DRIVE_W-1:0] auto_lvl;
  logic [16:0]        tmp_err;
  logic [20:0]        tmp_ext;
  logic [20:0]        tmp_prod;
  logic [DRIVE_W-1:0] auto_heat;
  logic [DRIVE_W-1:0] pump_dmd;
  logic [DRIVE_W-1:0] valve_dmd;
  logic [DRIVE_W-1:0] heat_dmd;

  assign fault     = !level_good || !temperature_good;
  assign low       = level_value <= cfg.low_alarm_level;
  assign high      = level_value >= cfg.high_alarm_level;
  assign below_min = level_value < cfg.min_heater_level;

  // level error times 205/256; sign bit picks pump or valve
  assign lvl_err  = {1'b0, cfg.target_level} - {1'b0, level_value};
  assign err_mag  = lvl_err[16] ? 16'(-lvl_err) : lvl_err[15:0];
  assign err_prod = 24'(err_mag) * 24'(GAIN_NUM);
  assign auto_lvl = sat_drive(err_prod[23:GAIN_SHIFT]);

  // temperature error times 10, clamped to 0..1600
  assign tmp_err  = {cfg.target_temperature[15], cfg.target_temperature}
                  - {temperature_value[15], temperature_value};
  assign tmp_ext  = {{4{tmp_err[16]}}, tmp_err};
  assign tmp_prod = (tmp_ext << 3) + (tmp_ext << 1);

  always_comb begin
    if (tmp_prod[20] || (tmp_prod == '0)) begin
      auto_heat = '0;
    end else if (tmp_prod > 21'(DRIVE_MAX)) begin
      auto_heat = DRIVE_MAX;
    end else begin
      auto_heat = tmp_prod[DRIVE_W-1:0];
    end
  end

  // demand before interlocks
  always_comb begin
    if (cfg.run_mode == MODE_MANUAL) begin
      pump_dmd  = sat_drive(16'(cfg.manual_drives[10:0]));
      valve_dmd = sat_drive(16'(cfg.manual_drives[21:11]));
      heat_dmd  = sat_drive(16'(cfg.manual_drives[32:22]));
    end else begin
      pump_dmd  = lvl_err[16] ? '0 : auto_lvl;
      valve_dmd = lvl_err[16] ? auto_lvl : '0;
      heat_dmd  = auto_heat;
    end
  end

  // mode, fault and interlock selection
  always_comb begin
    res = '0;
    res.sample_fault = fault;
    if (cfg.run_mode == MODE_STOPPED) begin
      state_next = ST_IDLE;
    end else if (fault) begin
      state_next     = ST_FAULTED;
      res.safe_state = 1'b1;
    end else begin
      state_next           = ST_RUNNING;
      res.low_level_alarm  = low;
      res.high_level_alarm = high;
      res.heater_lockout   = below_min && (heat_dmd != '0);
      res.valve_drive      = valve_dmd;
      res.heater_drive     = (below_min || low) ? '0 : heat_dmd;
      res.pump_drive       = ((level_value >= cfg.max_fill_level) || high) ? '0 : pump_dmd;
    end
  end

endmodule

FILE: design/tank_level_heater_interlock_controller_top.sv
// ----------------------------------------------------------------------------
// tank_level_heater_interlock_controller_top: tank level and heater control
// Path: input register, then result register around one pass of control and
//   interlock logic.
// Throughput: one item per cycle unless out_ready stalls the result register.
// Reset: synchronous rst clears valids and run state, config registers to defaults.
// ----------------------------------------------------------------------------
module tank_level_heater_interlock_controller_top import tlhic_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        level_value,
  input  logic               level_good,
  input  logic [15:0]        temperature_value,
  input  logic               temperature_good,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DRIVE_W-1:0] pump_drive,
  output logic [DRIVE_W-1:0] valve_drive,
  output logic [DRIVE_W-1:0] heater_drive,
  output logic               sample_fault,
  output logic               safe_state,
  output logic               low_level_alarm,
  output logic               high_level_alarm,
  output logic               heater_lockout,
  output logic [1:0]         controller_state
);

  cfg_t        cfg;
  logic        mode_wr;
  logic        s1_valid;
  logic [15:0] s1_level;
  logic        s1_lgood;
  logic [15:0] s1_temp;
  logic        s1_tgood;
  logic        advance;
  result_t     res_next;
  result_t     res;
  logic [1:0]  state_next;
  logic [1:0]  run_state;

  tlhic_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .mode_wr (mode_wr)
  );

  tlhic_core u_core (
    .cfg               (cfg),
    .level_value       (s1_level),
    .level_good        (s1_lgood),
    .temperature_value (s1_temp),
    .temperature_good  (s1_tgood),
    .res               (res_next),
    .state_next        (state_next)
  );

  // pipeline flow: result register frees up when empty or taken
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_level <= level_value;
      s1_lgood <= level_good;
      s1_temp  <= temperature_value;
      s1_tgood <= temperature_good;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res <= res_next;
    end
  end

  // run state: set by mode writes, advanced by each item
  always_ff @(posedge clk) begin
    if (rst) begin
      run_state <= ST_IDLE;
    end else if (mode_wr) begin
      run_state <= (pwdata[1:0] == MODE_STOPPED) ? ST_IDLE : ST_STARTING;
    end else if (advance && s1_valid) begin
      run_state <= state_next;
    end
  end

  assign pump_drive       = res.pump_drive;
  assign valve_drive      = res.valve_drive;
  assign heater_drive     = res.heater_drive;
  assign sample_fault     = res.sample_fault;
  assign safe_state       = res.safe_state;
  assign low_level_alarm  = res.low_level_alarm;
  assign high_level_alarm = res.high_level_alarm;
  assign heater_lockout   = res.heater_lockout;
  assign controller_state = run_state;

  // checks
  a_safe_drives_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && safe_state |-> (pump_drive == '0) && (valve_drive == '0)
                                && (heater_drive == '0))
    else $error("drive active in safe state");

  a_safe_needs_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && safe_state |-> sample_fault)
    else $error("safe state without sensor fault");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pump_drive <= DRIVE_MAX) && (valve_drive <= DRIVE_MAX)
                  && (heater_drive <= DRIVE_MAX))
    else $error("drive above full scale");

  a_high_cuts_pump: assert property (@(posedge clk) disable iff (rst)
    out_valid && high_level_alarm |-> (pump_drive == '0))
    else $error("pump running with high level alarm");

endmodule
